/* rtl/lrusr_pkg.sv */
// Shared types and constants for the LRU slot replacement block.
package lrusr_pkg;

    localparam int IDENT_W = 16;
    localparam int STAMP_W = 32;

    localparam logic [STAMP_W-1:0] CLOCK_MAX = '1;

    // Request kinds
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_ACCESS = 1'b1;

    // Result status codes
    localparam logic [1:0] STATUS_INSERT = 2'd0;
    localparam logic [1:0] STATUS_EVICT  = 2'd1;
    localparam logic [1:0] STATUS_HIT    = 2'd2;
    localparam logic [1:0] STATUS_MISS   = 2'd3;

    // One slot as it is kept in the table memory
    typedef struct packed {
        logic [IDENT_W-1:0] ident;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_WRITE
    } t_state;

endpackage

/* rtl/lru_slot_replacement.sv */
// Top level of the LRU slot replacement table.
//
// Input channel: i_in_valid / o_in_stall with i_kind and i_ident. An item is
// taken at a rising edge with i_in_valid high and o_in_stall low. kind 0
// inserts ident, evicting the least recently stamped slot when all slots are
// in use; kind 1 stamps the first valid slot holding ident or reports a miss.
// Output channel: o_out_valid / i_out_stall, one result item per request
// (status, slot_index, evicted_valid, evicted_ident).
// Slot identifiers and stamps live in a one-port-read RAM; valid bits and
// the logical clock sit in flip-flops. Each request walks the RAM one slot
// a cycle (SLOTS reads), drains the last read, then writes back at most once
// (an access that misses writes nothing). A new item is taken only after
// the previous request has written back, as the slot walk goes through
// the single RAM read port.
// The result sits in an output register, so the next item is taken while
// a result still waits. If the receiver stalls, the write-back of the
// following item waits until the output register frees up.
// Reset (synchronous, active low) clears all valid bits, the clock and the
// output valid; it needs no clearing pass.
module lru_slot_replacement #(
    parameter int SLOTS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_kind,
    input  logic [15:0] i_ident,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [1:0]  o_slot_index,
    output logic        o_evicted_valid,
    output logic [15:0] o_evicted_ident
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    lrusr_pkg::t_state r_state, n_state;

    logic [IW-1:0]                   r_idx, n_idx;
    logic                            r_rd_pend;
    logic [IW-1:0]                   r_rd_idx;
    logic                            r_kind;
    logic [lrusr_pkg::IDENT_W-1:0]   r_ident;

    logic                            r_hit_found, r_vic_found, r_emp_found;
    logic [IW-1:0]                   r_hit_idx, r_vic_idx, r_emp_idx;
    logic [lrusr_pkg::IDENT_W-1:0]   r_vic_ident;
    logic [lrusr_pkg::STAMP_W-1:0]   r_best;

    logic [SLOTS-1:0]                r_valid;
    logic [lrusr_pkg::STAMP_W-1:0]   r_clock, n_clock;

    logic                            r_out_valid;
    logic [1:0]                      r_status;
    logic [1:0]                      r_slot;
    logic                            r_ev_valid;
    logic [lrusr_pkg::IDENT_W-1:0]   r_ev_ident;

    lrusr_pkg::t_entry               rd_entry, wr_entry;
    logic                            accept, issue, commit, out_free;
    logic                            we;
    logic [IW-1:0]                   tgt_idx;
    logic                            rd_valid_bit;

    assign accept   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign issue    = (r_state == lrusr_pkg::S_SCAN);
    assign commit   = (r_state == lrusr_pkg::S_WRITE) && out_free;

    // Slot table memory
    lrusr_ram #(
        .WIDTH ($bits(lrusr_pkg::t_entry)),
        .DEPTH (SLOTS),
        .AW    (IW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (tgt_idx),
        .i_wdata (wr_entry),
        .i_raddr (r_idx),
        .o_rdata (rd_entry)
    );

    // Sequencer: idle, walk, drain, write back
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        unique case (r_state)
            lrusr_pkg::S_IDLE: begin
                n_idx = '0;
                if (accept) begin
                    n_state = lrusr_pkg::S_SCAN;
                end
            end
            lrusr_pkg::S_SCAN: begin
                if (r_idx == LAST_IDX) begin
                    n_state = lrusr_pkg::S_DRAIN;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            lrusr_pkg::S_DRAIN: begin
                n_state = lrusr_pkg::S_WRITE;
            end
            lrusr_pkg::S_WRITE: begin
                if (out_free) begin
                    n_state = lrusr_pkg::S_IDLE;
                end
            end
            default: n_state = lrusr_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= lrusr_pkg::S_IDLE;
            r_rd_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= issue;
        end
        r_idx    <= n_idx;
        r_rd_idx <= r_idx;
    end

    assign o_in_stall = (r_state != lrusr_pkg::S_IDLE);

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind  <= i_kind;
            r_ident <= i_ident;
        end
    end

    // Evaluate each slot as its read data returns
    assign rd_valid_bit = r_valid[r_rd_idx];

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hit_found <= 1'b0;
            r_vic_found <= 1'b0;
            r_emp_found <= 1'b0;
        end else if (r_rd_pend) begin
            if (rd_valid_bit && !r_hit_found && rd_entry.ident == r_ident) begin
                r_hit_found <= 1'b1;
                r_hit_idx   <= r_rd_idx;
            end
            if (rd_valid_bit && (!r_vic_found || rd_entry.stamp < r_best)) begin
                r_vic_found <= 1'b1;
                r_vic_idx   <= r_rd_idx;
                r_vic_ident <= rd_entry.ident;
                r_best      <= rd_entry.stamp;
            end
            if (!rd_valid_bit && !r_emp_found) begin
                r_emp_found <= 1'b1;
                r_emp_idx   <= r_rd_idx;
            end
        end
    end

    // Write-back target and new stamp
    assign n_clock = (r_clock == lrusr_pkg::CLOCK_MAX) ? r_clock : r_clock + 1'b1;

    always_comb begin
        if (r_kind == lrusr_pkg::KIND_INSERT) begin
            tgt_idx = r_emp_found ? r_emp_idx : r_vic_idx;
            we      = commit;
        end else begin
            tgt_idx = r_hit_idx;
            we      = commit && r_hit_found;
        end
    end

    assign wr_entry.ident = r_ident;
    assign wr_entry.stamp = n_clock;

    // Update valid bits and the logical clock
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_clock <= '0;
        end else if (we) begin
            r_valid[tgt_idx] <= 1'b1;
            r_clock          <= n_clock;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (commit) begin
            if (r_kind == lrusr_pkg::KIND_INSERT) begin
                r_status   <= r_emp_found ? lrusr_pkg::STATUS_INSERT
                                          : lrusr_pkg::STATUS_EVICT;
                r_slot     <= 2'(tgt_idx);
                r_ev_valid <= !r_emp_found;
                r_ev_ident <= r_emp_found ? '0 : r_vic_ident;
            end else begin
                r_status   <= r_hit_found ? lrusr_pkg::STATUS_HIT
                                          : lrusr_pkg::STATUS_MISS;
                r_slot     <= r_hit_found ? 2'(r_hit_idx) : 2'd0;
                r_ev_valid <= 1'b0;
                r_ev_ident <= '0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_slot_index    = r_slot;
    assign o_evicted_valid = r_ev_valid;
    assign o_evicted_ident = r_ev_ident;

`ifndef SYNTH
    // A taken item locks the input until its result is written
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_in_stall)
        else $error("input taken while a request is in flight");

    // Read data only returns during the slot walk
    a_read_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |-> (r_state == lrusr_pkg::S_SCAN || r_state == lrusr_pkg::S_DRAIN))
        else $error("slot read returned outside the walk");

    // An eviction is reported only with the eviction status
    a_evict_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_evicted_valid) |-> (o_status == lrusr_pkg::STATUS_EVICT))
        else $error("eviction flagged with wrong status");

    // An insert without a free slot must have found a victim
    a_victim_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && r_kind == lrusr_pkg::KIND_INSERT && !r_emp_found) |-> r_vic_found)
        else $error("full table insert without a victim");
`endif

endmodule

/* rtl/lrusr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module lrusr_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* verif/tb.sv */
// Self-checking testbench for the LRU slot replacement table.
`timescale 1ns / 1ps

localparam int TABLE_SLOTS = 4;

typedef struct packed {
    logic [1:0]                    status;
    logic [1:0]                    slot;
    logic                          evicted;
    logic [lrusr_pkg::IDENT_W-1:0] evicted_id;
} t_lru_result;

// Shadow copy of the slot table; predicts one result item per request
class lru_table_scoreboard;
    logic                          slot_used [TABLE_SLOTS];
    logic [lrusr_pkg::IDENT_W-1:0] slot_id   [TABLE_SLOTS];
    logic [lrusr_pkg::STAMP_W-1:0] slot_age  [TABLE_SLOTS];
    logic [lrusr_pkg::STAMP_W-1:0] use_clock;
    int unsigned                   used_count;
    t_lru_result                   expected_results[$];
    int unsigned                   errors;

    function new();
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            slot_used[i] = 1'b0;
            slot_id[i]   = '0;
            slot_age[i]  = '0;
        end
        use_clock  = '0;
        used_count = 0;
        errors     = 0;
    endfunction

    // Advance the logical clock, holding at its maximum, and stamp one slot
    function void touch_slot(int s);
        if (use_clock != lrusr_pkg::CLOCK_MAX)
            use_clock = use_clock + 1'b1;
        slot_age[s] = use_clock;
    endfunction

    // Predict the result of one accepted request and update the shadow table
    function void note_request(logic kind, logic [lrusr_pkg::IDENT_W-1:0] ident);
        t_lru_result                   res;
        int                            victim;
        logic [lrusr_pkg::STAMP_W-1:0] oldest;
        bit                            found;
        res    = '0;
        victim = 0;
        oldest = '0;
        found  = 1'b0;
        if (kind == lrusr_pkg::KIND_INSERT) begin
            res.status = lrusr_pkg::STATUS_INSERT;
            // Evict the oldest valid slot when the table is full, lowest index on a tie
            if (used_count >= TABLE_SLOTS) begin
                for (int i = 0; i < TABLE_SLOTS; i++) begin
                    if (slot_used[i] && (!found || slot_age[i] < oldest)) begin
                        found  = 1'b1;
                        oldest = slot_age[i];
                        victim = i;
                    end
                end
                if (found) begin
                    res.status     = lrusr_pkg::STATUS_EVICT;
                    res.evicted    = 1'b1;
                    res.evicted_id = slot_id[victim];
                    slot_used[victim] = 1'b0;
                    used_count--;
                end
            end
            // Fill the first empty slot
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                if (!slot_used[i]) begin
                    slot_used[i] = 1'b1;
                    slot_id[i]   = ident;
                    touch_slot(i);
                    used_count++;
                    res.slot = i[1:0];
                    break;
                end
            end
        end else begin
            res.status = lrusr_pkg::STATUS_MISS;
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                if (slot_used[i] && slot_id[i] == ident) begin
                    touch_slot(i);
                    res.status = lrusr_pkg::STATUS_HIT;
                    res.slot   = i[1:0];
                    break;
                end
            end
        end
        expected_results.push_back(res);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    // Compare one accepted result item against the oldest prediction
    function void check_result(t_lru_result got);
        t_lru_result want;
        if (expected_results.size() == 0) begin
            $display("%0t: unexpected result item, status %0d slot %0d", $time,
                     got.status, got.slot);
            errors++;
            return;
        end
        want = expected_results.pop_front();
        compare_field("status", want.status, got.status);
        compare_field("slot_index", want.slot, got.slot);
        compare_field("evicted_valid", want.evicted, got.evicted);
        compare_field("evicted_ident", want.evicted_id, got.evicted_id);
    endfunction

    function int outstanding();
        return expected_results.size();
    endfunction
endclass

module tb;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_in_valid  = 1'b0;
    logic                          i_kind      = lrusr_pkg::KIND_INSERT;
    logic [lrusr_pkg::IDENT_W-1:0] i_ident     = '0;
    logic                          i_out_stall = 1'b0;
    logic                          o_in_stall;
    logic                          o_out_valid;
    logic [1:0]                    o_status;
    logic [1:0]                    o_slot_index;
    logic                          o_evicted_valid;
    logic [lrusr_pkg::IDENT_W-1:0] o_evicted_ident;

    lru_table_scoreboard           sb = new();
    bit                            quiet_phase = 1'b0;
    logic [lrusr_pkg::IDENT_W-1:0] recent_ids [8];

    lru_slot_replacement #(.SLOTS(TABLE_SLOTS)) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_kind          (i_kind),
        .i_ident         (i_ident),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_slot_index    (o_slot_index),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_ident (o_evicted_ident)
    );

    always #2 i_clk = ~i_clk;

    // Send one request item; entered and left at a falling edge
    task automatic send_request(input logic kind,
                                input logic [lrusr_pkg::IDENT_W-1:0] ident);
        int gap;
        gap = quiet_phase ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_ident    <= ident;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(kind, ident);
        @(negedge i_clk);
    endtask

    // Draw an identifier, mostly from recently used ones so accesses hit
    function automatic logic [lrusr_pkg::IDENT_W-1:0] pick_ident(int reuse_pct);
        if ($urandom_range(0, 99) < reuse_pct)
            return recent_ids[$urandom_range(0, 7)];
        return lrusr_pkg::IDENT_W'($urandom_range(0, 65535));
    endfunction

    // Check every accepted result item
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result('{o_status, o_slot_index, o_evicted_valid, o_evicted_ident});
    end

    // Receiver: stall a random number of cycles before taking each item
    initial begin
        int hold;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            hold = quiet_phase ? 0 : $urandom_range(0, 7);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    // Main sequence
    initial begin
        logic                          dir_kind [20];
        logic [lrusr_pkg::IDENT_W-1:0] dir_id   [20];
        logic                          kind;
        logic [lrusr_pkg::IDENT_W-1:0] ident;

        // Empty-table miss, duplicates, lowest-copy hits, evictions by age
        dir_kind = '{lrusr_pkg::KIND_ACCESS, lrusr_pkg::KIND_INSERT,
                     lrusr_pkg::KIND_INSERT, lrusr_pkg::KIND_INSERT,
                     lrusr_pkg::KIND_INSERT, lrusr_pkg::KIND_ACCESS,
                     lrusr_pkg::KIND_ACCESS, lrusr_pkg::KIND_ACCESS,
                     lrusr_pkg::KIND_INSERT, lrusr_pkg::KIND_INSERT,
                     lrusr_pkg::KIND_ACCESS, lrusr_pkg::KIND_INSERT,
                     lrusr_pkg::KIND_INSERT, lrusr_pkg::KIND_ACCESS,
                     lrusr_pkg::KIND_ACCESS, lrusr_pkg::KIND_INSERT,
                     lrusr_pkg::KIND_INSERT, lrusr_pkg::KIND_INSERT,
                     lrusr_pkg::KIND_ACCESS, lrusr_pkg::KIND_ACCESS};
        dir_id   = '{16'h0000, 16'h0000, 16'hFFFF, 16'h1234, 16'hFFFF,
                     16'hFFFF, 16'h0000, 16'h5555, 16'hAAAA, 16'h5555,
                     16'hFFFF, 16'h8001, 16'h7FFE, 16'h1234, 16'h5555,
                     16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hAAAA};
        for (int i = 0; i < 8; i++)
            recent_ids[i] = lrusr_pkg::IDENT_W'($urandom_range(0, 65535));

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < 20; i++)
            send_request(dir_kind[i], dir_id[i]);

        // Random traffic with reuse; alternate idle and back-to-back stretches
        for (int n = 0; n < 1500; n++) begin
            quiet_phase = (n % 250) >= 200;
            kind = $urandom_range(0, 1) ? lrusr_pkg::KIND_ACCESS : lrusr_pkg::KIND_INSERT;
            if (kind == lrusr_pkg::KIND_INSERT) begin
                ident = pick_ident(40);
                recent_ids[$urandom_range(0, 7)] = ident;
            end else begin
                ident = pick_ident(80);
            end
            send_request(kind, ident);
        end
        i_in_valid  <= 1'b0;
        quiet_phase = 1'b0;

        // Drain outstanding results, then let the pipeline settle
        while (sb.outstanding() != 0)
            @(posedge i_clk);
        repeat (4 * TABLE_SLOTS) @(posedge i_clk);

        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    // Hang guard
    initial begin
        #2_000_000;
        $display("tb: FAIL");
        $finish;
    end

endmodule

/* lru_slot_replacement.f */
rtl/lrusr_pkg.sv
rtl/lrusr_ram.sv
rtl/lru_slot_replacement.sv
verif/tb.sv
